/* hw/rtl/cyclic_15_11_stream_encoder_macros.svh */
// Assertion macros shared by the encoder RTL.
`ifndef CYCLIC_15_11_STREAM_ENCODER_MACROS_SVH
`define CYCLIC_15_11_STREAM_ENCODER_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define CYC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a condition in the cycle after its trigger.
`define CYC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/cyc_enc_pkg.sv */
// Constants, types and helper functions of the (15,11) cyclic stream encoder.
package cyc_enc_pkg;

   localparam int DATA_W      = 8;
   localparam int MSG_LEN_W   = 24;
   localparam int BLOCK_BITS  = 11;
   localparam int CODE_BITS   = 15;
   localparam int CHECK_BITS  = 4;
   localparam int MAX_RES     = 5;
   localparam int QDEPTH      = 8;
   localparam int QCOUNT_W    = $clog2(QDEPTH + 1);
   localparam int SLOT_IDX_W  = $clog2(MAX_RES);

   // Remainder of x^(i+4) modulo x^4+x^3+1, one column per data bit.
   localparam logic [CHECK_BITS-1:0] CHECK_COLS [BLOCK_BITS] = '{
      4'h9, 4'hB, 4'hF, 4'h7, 4'hE, 4'h5, 4'hA, 4'hD, 4'h3, 4'h6, 4'hC
   };

   typedef struct packed {
      logic [DATA_W-1:0] data;
      logic              last;
   } rsp_entry_type;

   function automatic logic [CHECK_BITS-1:0] check_bits(input logic [BLOCK_BITS-1:0] d);
      logic [CHECK_BITS-1:0] acc;
      acc = '0;
      for (int i = 0; i < BLOCK_BITS; i++) begin
         if (d[i]) begin
            acc = acc ^ CHECK_COLS[i];
         end
      end
      return acc;
   endfunction

   function automatic logic [DATA_W-1:0] rev8(input logic [DATA_W-1:0] v);
      logic [DATA_W-1:0] r;
      for (int i = 0; i < DATA_W; i++) begin
         r[i] = v[DATA_W-1-i];
      end
      return r;
   endfunction

   function automatic logic [CODE_BITS-1:0] rev15(input logic [CODE_BITS-1:0] v);
      logic [CODE_BITS-1:0] r;
      for (int i = 0; i < CODE_BITS; i++) begin
         r[i] = v[CODE_BITS-1-i];
      end
      return r;
   endfunction

   // 2^10 = 1 and 2^5 = -1 modulo 11: fold the word down, then a short compare chain.
   function automatic logic [3:0] mod11(input logic [MSG_LEN_W-1:0] v);
      logic [11:0] s1;
      logic [10:0] s2;
      logic [6:0]  s3;
      logic [6:0]  t;
      s1 = 12'(v[9:0]) + 12'(v[19:10]) + 12'(v[23:20]);
      s2 = 11'(s1[9:0]) + 11'(s1[11:10]);
      s3 = 7'(s2[4:0]) + 7'd33 - 7'(s2[10:5]);
      if (s3 >= 7'd55) begin
         t = s3 - 7'd55;
      end else if (s3 >= 7'd44) begin
         t = s3 - 7'd44;
      end else if (s3 >= 7'd33) begin
         t = s3 - 7'd33;
      end else if (s3 >= 7'd22) begin
         t = s3 - 7'd22;
      end else if (s3 >= 7'd11) begin
         t = s3 - 7'd11;
      end else begin
         t = s3;
      end
      return t[3:0];
   endfunction

   // Tail pad bits of the output, from the length modulo 11.
   function automatic logic [DATA_W-1:0] hdr_tail(input logic [3:0] m);
      logic [DATA_W-1:0] r;
      case (m)
         4'd0:    r = 8'd0;
         4'd1:    r = 8'd1;
         4'd2:    r = 8'd2;
         4'd3:    r = 8'd3;
         4'd4:    r = 8'd3;
         4'd5:    r = 8'd4;
         4'd6:    r = 8'd5;
         4'd7:    r = 8'd6;
         4'd8:    r = 8'd6;
         4'd9:    r = 8'd7;
         4'd10:   r = 8'd0;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

   // Zero bits filling the last data block, from the length modulo 11.
   function automatic logic [DATA_W-1:0] hdr_fill(input logic [3:0] m);
      logic [DATA_W-1:0] r;
      case (m)
         4'd0:    r = 8'd0;
         4'd1:    r = 8'd3;
         4'd2:    r = 8'd6;
         4'd3:    r = 8'd9;
         4'd4:    r = 8'd1;
         4'd5:    r = 8'd4;
         4'd6:    r = 8'd7;
         4'd7:    r = 8'd10;
         4'd8:    r = 8'd2;
         4'd9:    r = 8'd5;
         4'd10:   r = 8'd8;
         default: r = 8'd0;
      endcase
      return r;
   endfunction

endpackage

/* hw/rtl/cyclic_15_11_stream_encoder.sv */
// Streaming encoder: message bytes in, (15,11) cyclic-coded bytes with a two-byte header out.
//
// req_* carries one message byte per beat; rsp_* carries one encoded byte per beat,
// with rsp_tlast high on the final byte of each message. csr_wen/csr_wdata set the
// message length in bytes (zero counts as one); write it only between messages.
// Each message opens with two header bytes (tail pad bits, fill bits of the last
// block), then the codewords, four check bits first, packed MSB first.
// An accepted byte waits in the input register and is encoded straight from it
// when the encode step fires; its results enter an 8-entry output queue at the edge
// that ends the firing cycle, and rsp_tvalid is high while the queue holds a byte.
// The encode step takes an input byte every cycle while the queue holds at most
// three bytes, and the queue drains one byte a cycle while rsp_tready is high, so
// the output port sets the rate: about 1.4 output bytes per input byte plus two
// header bytes per message.
// Reset empties the queue and input register, clears the partial block and
// partial byte and sets the length to one. When rsp_tready is low the queue
// holds, and req_tready falls once the input register is full and the queue
// cannot take a further five bytes.
`include "cyclic_15_11_stream_encoder_macros.svh"

module cyclic_15_11_stream_encoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [cyc_enc_pkg::DATA_W-1:0]     req_tdata,   // [7:0] data_byte
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [cyc_enc_pkg::DATA_W-1:0]     rsp_tdata,   // [7:0] out_byte
   output logic                               rsp_tlast,
   input  logic                               csr_wen,
   input  logic [cyc_enc_pkg::MSG_LEN_W-1:0]  csr_wdata
);
   import cyc_enc_pkg::*;

   // configuration
   logic [MSG_LEN_W-1:0]  len_ff, len_in;
   logic [3:0]            len_mod_ff, len_mod_in;

   // input register
   logic                  in_valid_ff, in_valid_in;
   logic [DATA_W-1:0]     in_byte_ff, in_byte_in;

   // encoder state
   logic [MSG_LEN_W-1:0]  taken_ff, taken_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [3:0]            blk_fill_ff, blk_fill_in;
   logic [DATA_W-1:0]     pend_ff, pend_in;      // left-aligned, oldest bit in bit 7
   logic [2:0]            pend_fill_ff, pend_fill_in;
   logic                  hdr_sent_ff, hdr_sent_in;

   // output queue
   rsp_entry_type         q_ff [QDEPTH];
   rsp_entry_type         q_in [QDEPTH];
   rsp_entry_type         q_shift [QDEPTH];
   logic [QCOUNT_W-1:0]   count_ff, count_in;

   // encode step
   logic                  fire, pop, is_end, emit1, hdr;
   logic [DATA_W-1:0]     rbyte;
   logic [18:0]           wbits;
   logic [4:0]            fill_sum;
   logic [BLOCK_BITS-1:0] rem, blk_a, blk_b;
   logic [3:0]            rem_fill;
   logic [1:0]            nblk;
   logic [CODE_BITS-1:0]  cw_a, cw_b;
   logic [MSG_LEN_W-1:0]  taken_next;
   logic [5:0]            nbits;
   logic [39:0]           s_bits;
   logic [4:0][7:0]       s_bytes;
   logic [2:0]            data_cnt, batch_cnt;
   rsp_entry_type         slot [MAX_RES];
   logic [QCOUNT_W-1:0]   base;
   logic [QCOUNT_W-1:0]   rel;

   assign fire       = in_valid_ff && (count_ff <= QCOUNT_W'(QDEPTH - MAX_RES));
   assign req_tready = !in_valid_ff || fire;
   assign rsp_tvalid = (count_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = q_ff[0].data;
   assign rsp_tlast  = q_ff[0].last;

   always_comb begin
      len_in     = len_ff;
      len_mod_in = len_mod_ff;
      if (csr_wen) begin
         if (csr_wdata == '0) begin
            len_in     = MSG_LEN_W'(1);
            len_mod_in = 4'd1;
         end else begin
            len_in     = csr_wdata;
            len_mod_in = mod11(csr_wdata);
         end
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   // Append the byte to the open block; at most one block fills per byte, and a message end may flush a second.
   always_comb begin
      rbyte    = rev8(in_byte_ff);
      wbits    = 19'(blk_ff) | (19'(rbyte) << blk_fill_ff);
      fill_sum = 5'(blk_fill_ff) + 5'd8;
      emit1    = (fill_sum >= 5'(BLOCK_BITS));
      if (emit1) begin
         rem      = BLOCK_BITS'(wbits[18:11]);
         rem_fill = 4'(fill_sum - 5'(BLOCK_BITS));
      end else begin
         rem      = wbits[BLOCK_BITS-1:0];
         rem_fill = 4'(fill_sum);
      end
      taken_next = taken_ff + MSG_LEN_W'(1);
      is_end     = (taken_next >= len_ff);
      hdr        = !hdr_sent_ff;

      // pick the blocks to emit, flushing the open block at message end
      if (emit1) begin
         blk_a = wbits[BLOCK_BITS-1:0];
         blk_b = rem;
         nblk  = (is_end && rem_fill != 4'd0) ? 2'd2 : 2'd1;
      end else begin
         blk_a = rem;
         blk_b = rem;
         nblk  = (is_end && rem_fill != 4'd0) ? 2'd1 : 2'd0;
      end
      cw_a = {blk_a, check_bits(blk_a)};
      cw_b = {blk_b, check_bits(blk_b)};

      nbits = 6'(pend_fill_ff);
      if (nblk == 2'd1) begin
         nbits = nbits + 6'(CODE_BITS);
      end else if (nblk == 2'd2) begin
         nbits = nbits + 6'(2 * CODE_BITS);
      end

      // output bit stream, first bit in bit 39
      s_bits = {pend_ff, 32'b0};
      if (nblk != 2'd0) begin
         s_bits = s_bits | ({rev15(cw_a), 25'b0} >> pend_fill_ff);
      end
      if (nblk == 2'd2) begin
         s_bits = s_bits | ({rev15(cw_b), 25'b0} >> (6'(pend_fill_ff) + 6'(CODE_BITS)));
      end
      s_bytes = s_bits;

      data_cnt  = is_end ? 3'((nbits + 6'd7) >> 3) : 3'(nbits >> 3);
      batch_cnt = data_cnt + (hdr ? 3'd2 : 3'd0);

      for (int j = 0; j < MAX_RES; j++) begin
         if (hdr && j == 0) begin
            slot[j].data = hdr_tail(len_mod_ff);
         end else if (hdr && j == 1) begin
            slot[j].data = hdr_fill(len_mod_ff);
         end else if (hdr) begin
            slot[j].data = s_bytes[3'(6 - j)];
         end else begin
            slot[j].data = s_bytes[3'(4 - j)];
         end
         slot[j].last = is_end && (3'(j) == batch_cnt - 3'd1);
      end

      taken_in     = taken_ff;
      blk_in       = blk_ff;
      blk_fill_in  = blk_fill_ff;
      pend_in      = pend_ff;
      pend_fill_in = pend_fill_ff;
      hdr_sent_in  = hdr_sent_ff;
      if (fire) begin
         if (is_end) begin
            taken_in     = '0;
            blk_in       = '0;
            blk_fill_in  = '0;
            pend_in      = '0;
            pend_fill_in = '0;
            hdr_sent_in  = 1'b0;
         end else begin
            taken_in     = taken_next;
            blk_in       = rem;
            blk_fill_in  = rem_fill;
            pend_in      = s_bytes[3'(3'd4 - nbits[5:3])];
            pend_fill_in = nbits[2:0];
            hdr_sent_in  = 1'b1;
         end
      end
   end

   // Advance the queue on a taken beat, append the new batch behind what stays.
   always_comb begin
      for (int i = 0; i < QDEPTH - 1; i++) begin
         q_shift[i] = pop ? q_ff[i+1] : q_ff[i];
      end
      q_shift[QDEPTH-1] = q_ff[QDEPTH-1];
      base = count_ff - QCOUNT_W'(pop);
      for (int i = 0; i < QDEPTH; i++) begin
         rel     = QCOUNT_W'(i) - base;
         q_in[i] = q_shift[i];
         if (fire && QCOUNT_W'(i) >= base && rel < QCOUNT_W'(batch_cnt)) begin
            q_in[i] = slot[rel[SLOT_IDX_W-1:0]];
         end
      end
      count_in = base + (fire ? QCOUNT_W'(batch_cnt) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= MSG_LEN_W'(1);
         len_mod_ff   <= 4'd1;
         in_valid_ff  <= 1'b0;
         taken_ff     <= '0;
         blk_ff       <= '0;
         blk_fill_ff  <= '0;
         pend_ff      <= '0;
         pend_fill_ff <= '0;
         hdr_sent_ff  <= 1'b0;
         count_ff     <= '0;
      end else begin
         len_ff       <= len_in;
         len_mod_ff   <= len_mod_in;
         in_valid_ff  <= in_valid_in;
         taken_ff     <= taken_in;
         blk_ff       <= blk_in;
         blk_fill_ff  <= blk_fill_in;
         pend_ff      <= pend_in;
         pend_fill_ff <= pend_fill_in;
         hdr_sent_ff  <= hdr_sent_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
      for (int i = 0; i < QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   `CYC_ASSERT_NOW(a_end_has_result, fire && is_end, batch_cnt != 3'd0, "message end without result")
   `CYC_ASSERT_NEXT(a_end_clears, fire && is_end, blk_fill_ff == 4'd0 && pend_fill_ff == 3'd0 && !hdr_sent_ff, "state not cleared after message end")
   `CYC_ASSERT_NEXT(a_block_bound, fire, blk_fill_ff < 4'(BLOCK_BITS), "open block overfilled")
   `CYC_ASSERT_NEXT(a_input_hold, in_valid_ff && !fire, in_valid_ff && $stable(in_byte_ff), "stalled input byte lost")

endmodule
